/* src/mts_pkg.sv */
package mts_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int DATA_W        = 32;
    localparam int STATUS_W      = 2;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_POP_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_PUSH_FULL = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_FETCH
    } mts_state_t;

endpackage

/* src/min_tracking_stack.sv */
// Push, pop on empty and push on full: result valid in the cycle after the transaction.
// Pop: the transaction moves to ST_FETCH, where the registered read of the value and
// minimum memories refills the top caches; the result is registered from ST_FETCH.
// Throughput: one push per cycle unless m_ready stalls; no input is taken in ST_FETCH.
// Reset (aresetn low, synchronous): counts, top caches, state and result valid clear;
// the memory contents are not cleared; a never-written entry is never used as a result.
module min_tracking_stack
    import mts_pkg::*;
#(
    parameter int STACK_DEPTH = DEPTH_DEFAULT,
    localparam int AW         = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
    localparam int CW         = $clog2(STACK_DEPTH + 1)
) (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_action,
    input  logic signed [DATA_W-1:0]   s_push_value,

    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [DATA_W-1:0]   m_top_value,
    output logic signed [DATA_W-1:0]   m_min_value,
    output logic                       m_is_empty,
    output logic [CW-1:0]              m_fill_count,
    output logic [STATUS_W-1:0]        m_status
);

    mts_state_t                state_reg, state_next;
    logic [CW-1:0]             vcnt_reg, vcnt_next;
    logic [CW-1:0]             mcnt_reg, mcnt_next;
    logic signed [DATA_W-1:0]  top_reg, top_next;
    logic signed [DATA_W-1:0]  min_reg, min_next;
    logic                      min_pop_reg, min_pop_next;

    logic                      m_valid_reg, m_valid_next;
    logic signed [DATA_W-1:0]  m_top_reg, m_min_reg;
    logic                      m_empty_reg;
    logic [CW-1:0]             m_fill_reg;
    logic [STATUS_W-1:0]       m_status_reg, status_next;
    logic                      out_load;

    logic                      v_wr_en, m_wr_en, rd_en;
    logic [DATA_W-1:0]         v_rd_data, m_rd_data;
    logic                      push_min;

    mts_ram #(.DEPTH(STACK_DEPTH), .WIDTH(DATA_W)) u_value_ram (
        .aclk    (aclk),
        .wr_en   (v_wr_en),
        .wr_addr (vcnt_reg[AW-1:0]),
        .wr_data (s_push_value),
        .rd_en   (rd_en),
        .rd_addr (AW'(vcnt_reg - CW'(2))),
        .rd_data (v_rd_data)
    );

    mts_ram #(.DEPTH(STACK_DEPTH), .WIDTH(DATA_W)) u_min_ram (
        .aclk    (aclk),
        .wr_en   (m_wr_en),
        .wr_addr (mcnt_reg[AW-1:0]),
        .wr_data (s_push_value),
        .rd_en   (rd_en),
        .rd_addr (AW'(mcnt_reg - CW'(2))),
        .rd_data (m_rd_data)
    );

    assign s_ready  = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign push_min = (mcnt_reg == '0) || (s_push_value <= min_reg);

    always_comb begin
        state_next   = state_reg;
        vcnt_next    = vcnt_reg;
        mcnt_next    = mcnt_reg;
        top_next     = top_reg;
        min_next     = min_reg;
        min_pop_next = min_pop_reg;
        status_next  = STATUS_OK;
        v_wr_en      = 1'b0;
        m_wr_en      = 1'b0;
        rd_en        = 1'b0;
        out_load     = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    if (s_action == ACT_PUSH) begin
                        out_load = 1'b1;
                        if (vcnt_reg == CW'(STACK_DEPTH)) begin
                            status_next = STATUS_PUSH_FULL;
                        end else begin
                            v_wr_en   = 1'b1;
                            vcnt_next = vcnt_reg + CW'(1);
                            top_next  = s_push_value;
                            if (push_min) begin
                                m_wr_en   = 1'b1;
                                mcnt_next = mcnt_reg + CW'(1);
                                min_next  = s_push_value;
                            end
                        end
                    end else if (vcnt_reg == '0) begin
                        out_load    = 1'b1;
                        status_next = STATUS_POP_EMPTY;
                    end else begin
                        // drop the top, fetch the entries below to refill the caches
                        vcnt_next    = vcnt_reg - CW'(1);
                        min_pop_next = (top_reg == min_reg);
                        if (top_reg == min_reg) begin
                            mcnt_next = mcnt_reg - CW'(1);
                        end
                        rd_en      = 1'b1;
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                top_next = (vcnt_reg != '0) ? v_rd_data : '0;
                if (min_pop_reg) begin
                    min_next = (mcnt_reg != '0) ? m_rd_data : '0;
                end
                out_load   = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            vcnt_reg    <= '0;
            mcnt_reg    <= '0;
            top_reg     <= '0;
            min_reg     <= '0;
            min_pop_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            vcnt_reg    <= vcnt_next;
            mcnt_reg    <= mcnt_next;
            top_reg     <= top_next;
            min_reg     <= min_next;
            min_pop_reg <= min_pop_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_top_reg    <= top_next;
            m_min_reg    <= min_next;
            m_empty_reg  <= (vcnt_next == '0);
            m_fill_reg   <= vcnt_next;
            m_status_reg <= status_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_top_value  = m_top_reg;
    assign m_min_value  = m_min_reg;
    assign m_is_empty   = m_empty_reg;
    assign m_fill_count = m_fill_reg;
    assign m_status     = m_status_reg;

endmodule

/* src/mts_ram.sv */
module mts_ram
    import mts_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int WIDTH = DATA_W,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
